/* src/adq_pkg.sv */
// ----------------------------------------------------------------------------
// adq_pkg
// shared types and constants for the alarm delta queue and its slot cells
// ----------------------------------------------------------------------------
package adq_pkg;

    localparam int unsigned OWNER_W    = 8;
    localparam int unsigned SECONDS_W  = 16;
    localparam int unsigned TPS_W      = 10;
    localparam int unsigned REMAIN_W   = 27;

    // at most this many alarms fire on one tick
    localparam int unsigned RESULT_LIMIT = 16;
    localparam int unsigned FIRE_CNT_W   = $clog2(RESULT_LIMIT);

    localparam logic [TPS_W-1:0] TPS_RESET = 10'd100;

    // operation codes of an input transaction
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // event kinds of a result transaction
    localparam logic EV_FIRED  = 1'b0;
    localparam logic EV_REJECT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_FIRE
    } adq_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DECR,
        CELL_SHIFT
    } cell_cmd_t;

    // contents of one slot
    typedef struct packed {
        logic                valid;
        logic [OWNER_W-1:0]  owner;
        logic [REMAIN_W-1:0] remaining;
    } cell_data_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        cell_cmd_t           cmd;
        logic [REMAIN_W-1:0] ticks;
        logic [OWNER_W-1:0]  new_owner;
    } cell_ctrl_t;

endpackage

/* src/alarm_delta_queue.sv */
// ----------------------------------------------------------------------------
// alarm_delta_queue
// pool of alarm slots kept in expiry order in a chain of cells; set inserts
// an alarm, tick counts every alarm down and fires the ones that are due
// ----------------------------------------------------------------------------
//
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+------------------------
// command   | operation, requester_id, delay_seconds       | start high, busy low
// result    | event_kind, target_id, last_of_run           | result_strobe, 1 cycle
// config    | cfg_wdata (ticks_per_second)                 | cfg_we
//
// set: the delay is accepted, scaled and registered in the idle state, then
//   all cells insert in parallel in the insert state; a set into a full pool
//   is rejected at once and its reject transaction shows up in the next cycle
// tick: all cells count down, then due alarms pop from the head one by one
//   (at most 16) until none is due; the head cell sets the pace
// reset clears all slot valid bits at once and loads ticks_per_second = 100
// results cannot be stalled; each result transaction is on the ports for
//   exactly one cycle
// ----------------------------------------------------------------------------
module alarm_delta_queue
#(
    parameter int unsigned ALARM_SLOTS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // command transaction
    input  logic                            start,
    output logic                            busy,
    input  logic                            operation,
    input  logic [adq_pkg::OWNER_W-1:0]     requester_id,
    input  logic [adq_pkg::SECONDS_W-1:0]   delay_seconds,
    // result transaction
    output logic                            result_strobe,
    output logic                            event_kind,
    output logic [adq_pkg::OWNER_W-1:0]     target_id,
    output logic                            last_of_run,
    // ticks_per_second register
    input  logic                            cfg_we,
    input  logic [adq_pkg::TPS_W-1:0]       cfg_wdata
);

    adq_pkg::adq_state_t            state_reg;
    adq_pkg::adq_state_t            state_next;
    logic [adq_pkg::TPS_W-1:0]      tps_reg;
    logic [adq_pkg::REMAIN_W-1:0]   ticks_reg;
    logic [adq_pkg::OWNER_W-1:0]    id_reg;
    logic [adq_pkg::FIRE_CNT_W-1:0] fire_cnt_reg;
    logic [adq_pkg::FIRE_CNT_W-1:0] fire_cnt_next;

    // output registers
    logic                           strobe_reg;
    logic                           strobe_next;
    logic                           kind_reg;
    logic                           kind_next;
    logic [adq_pkg::OWNER_W-1:0]    target_reg;
    logic [adq_pkg::OWNER_W-1:0]    target_next;
    logic                           last_reg;
    logic                           last_next;

    // cell chain
    adq_pkg::cell_ctrl_t            cell_ctrl;
    adq_pkg::cell_data_t            cell_q    [ALARM_SLOTS];
    logic                           cell_keep [ALARM_SLOTS];

    logic                           pool_full;
    logic                           head_due;
    logic                           second_due;
    logic                           accept;
    logic [adq_pkg::REMAIN_W-1:0]   scaled_ticks;

    assign busy      = (state_reg != adq_pkg::ST_IDLE);
    assign accept    = start && !busy;
    // packed pool: full when the tail cell holds an alarm
    assign pool_full = cell_q[ALARM_SLOTS-1].valid;
    assign head_due  = cell_q[0].valid && (cell_q[0].remaining == '0);
    assign second_due = cell_q[1].valid && (cell_q[1].remaining == '0);

    // 16 x 10 product always fits the remaining-time width
    assign scaled_ticks = adq_pkg::REMAIN_W'(delay_seconds * tps_reg);

    // ------------------------------------------------------------------
    // sequencer: next state, cell command and result transaction
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next          = state_reg;
        cell_ctrl.cmd       = adq_pkg::CELL_HOLD;
        cell_ctrl.ticks     = ticks_reg;
        cell_ctrl.new_owner = id_reg;
        fire_cnt_next       = fire_cnt_reg;
        strobe_next         = 1'b0;
        kind_next           = kind_reg;
        target_next         = target_reg;
        last_next           = last_reg;
        case (state_reg)
            adq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == adq_pkg::OP_SET)
                    begin
                        if (pool_full)
                        begin
                            // reject right away, pool stays as it is
                            strobe_next = 1'b1;
                            kind_next   = adq_pkg::EV_REJECT;
                            target_next = requester_id;
                            last_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = adq_pkg::ST_INSERT;
                        end
                    end
                    else
                    begin
                        // count every alarm down, firing follows
                        cell_ctrl.cmd = adq_pkg::CELL_DECR;
                        fire_cnt_next = '0;
                        state_next    = adq_pkg::ST_FIRE;
                    end
                end
            end
            adq_pkg::ST_INSERT:
            begin
                cell_ctrl.cmd = adq_pkg::CELL_INSERT;
                state_next    = adq_pkg::ST_IDLE;
            end
            adq_pkg::ST_FIRE:
            begin
                if (head_due)
                begin
                    // pop the head alarm, the chain moves one cell forward
                    cell_ctrl.cmd = adq_pkg::CELL_SHIFT;
                    strobe_next   = 1'b1;
                    kind_next     = adq_pkg::EV_FIRED;
                    target_next   = cell_q[0].owner;
                    last_next     = !second_due ||
                        (fire_cnt_reg == adq_pkg::FIRE_CNT_W'(adq_pkg::RESULT_LIMIT - 1));
                    fire_cnt_next = fire_cnt_reg + 1'b1;
                    if (last_next)
                    begin
                        state_next = adq_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    // nothing due on this tick
                    state_next = adq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = adq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= adq_pkg::ST_IDLE;
            fire_cnt_reg <= '0;
            strobe_reg   <= 1'b0;
            tps_reg      <= adq_pkg::TPS_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            fire_cnt_reg <= fire_cnt_next;
            strobe_reg   <= strobe_next;
            if (cfg_we)
            begin
                tps_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        target_reg <= target_next;
        last_reg   <= last_next;
        if (accept && (operation == adq_pkg::OP_SET))
        begin
            ticks_reg <= scaled_ticks;
            id_reg    <= requester_id;
        end
    end

    assign result_strobe = strobe_reg;
    assign event_kind    = kind_reg;
    assign target_id     = target_reg;
    assign last_of_run   = last_reg;

    // ------------------------------------------------------------------
    // chain of slot cells, position 0 is the earliest alarm
    // ------------------------------------------------------------------
    for (genvar i = 0; i < ALARM_SLOTS; i++)
    begin : g_cell
        logic                prev_keep;
        adq_pkg::cell_data_t prev_data;
        adq_pkg::cell_data_t next_data;

        if (i == 0)
        begin : g_head
            // new alarm lands here when nothing is ahead of it
            assign prev_keep = 1'b1;
            assign prev_data = '0;
        end
        else
        begin : g_body
            assign prev_keep = cell_keep[i-1];
            assign prev_data = cell_q[i-1];
        end

        if (i == ALARM_SLOTS - 1)
        begin : g_tail
            // empty slot shifts in at the tail
            assign next_data = '0;
        end
        else
        begin : g_inner
            assign next_data = cell_q[i+1];
        end

        adq_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .prev_keep (prev_keep),
            .prev_data (prev_data),
            .next_data (next_data),
            .data      (cell_q[i]),
            .keep      (cell_keep[i])
        );
    end

endmodule

/* src/adq_cell.sv */
// ----------------------------------------------------------------------------
// adq_cell
// one alarm slot of the chain: holds owner and ticks left, loads from either
// neighbor on insert or shift
// ----------------------------------------------------------------------------
module adq_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  adq_pkg::cell_ctrl_t ctrl,
    input  logic                prev_keep,
    input  adq_pkg::cell_data_t prev_data,
    input  adq_pkg::cell_data_t next_data,
    output adq_pkg::cell_data_t data,
    output logic                keep
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [adq_pkg::OWNER_W-1:0]  owner_reg;
    logic [adq_pkg::OWNER_W-1:0]  owner_next;
    logic [adq_pkg::REMAIN_W-1:0] remaining_reg;
    logic [adq_pkg::REMAIN_W-1:0] remaining_next;

    // slot stays ahead of a new alarm with the given expiry
    assign keep = valid_reg && (remaining_reg <= ctrl.ticks);

    always_comb
    begin
        valid_next     = valid_reg;
        owner_next     = owner_reg;
        remaining_next = remaining_reg;
        case (ctrl.cmd)
            adq_pkg::CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (prev_keep)
                    begin
                        valid_next     = 1'b1;
                        owner_next     = ctrl.new_owner;
                        remaining_next = ctrl.ticks;
                    end
                    else
                    begin
                        valid_next     = prev_data.valid;
                        owner_next     = prev_data.owner;
                        remaining_next = prev_data.remaining;
                    end
                end
            end
            adq_pkg::CELL_DECR:
            begin
                if (valid_reg && (remaining_reg != '0))
                begin
                    remaining_next = remaining_reg - 1'b1;
                end
            end
            adq_pkg::CELL_SHIFT:
            begin
                valid_next     = next_data.valid;
                owner_next     = next_data.owner;
                remaining_next = next_data.remaining;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_reg     <= owner_next;
        remaining_reg <= remaining_next;
    end

    assign data.valid     = valid_reg;
    assign data.owner     = owner_reg;
    assign data.remaining = remaining_reg;

endmodule
